>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the battery led indicator sequencer
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check under a synchronous reset, quiet while reset is high
`define BLI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");
// check at every clock edge, reset included
`define BLI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");
`else
`define BLI_ASSERT(label, clk, rst, prop)
`define BLI_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/bli_pkg.sv
// shared types, codes, reset values and the breathing table of the led sequencer
// no dependencies
package bli_pkg;

  // request command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LEVEL = 2'd1;
  localparam logic [1:0] CMD_POWER = 2'd2;

  // register indexes (word address bits)
  localparam logic [2:0] REG_LOW_THRESHOLD    = 3'd0;
  localparam logic [2:0] REG_FLASH_HALF       = 3'd1;
  localparam logic [2:0] REG_BREATHE_STEP     = 3'd2;
  localparam logic [2:0] REG_BRIGHTNESS_SCALE = 3'd3;
  localparam logic [2:0] REG_STARTUP_DELAY    = 3'd4;
  localparam logic [2:0] REG_YELLOW_GREEN     = 3'd5;

  // register reset values
  localparam logic [6:0]  LOW_THRESHOLD_RESET    = 7'd90;
  localparam logic [15:0] FLASH_HALF_RESET       = 16'd500;
  localparam logic [15:0] BREATHE_STEP_RESET     = 16'd30;
  localparam logic [7:0]  BRIGHTNESS_SCALE_RESET = 8'd180;
  localparam logic [15:0] STARTUP_DELAY_RESET    = 16'd3000;
  localparam logic [7:0]  YELLOW_GREEN_RESET     = 8'd200;

  localparam logic [6:0] LEVEL_FULL = 7'd100;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [1:0] {
    PAT_OFF,
    PAT_GREEN,
    PAT_BREATHE,
    PAT_FLASH
  } pattern_t;

  // access strobes into the state store
  typedef struct packed {
    logic rd_en;
    logic status_we;
    logic timer_we;
  } mem_ctrl_t;

  // raised cosine, 64 steps
  localparam logic [7:0] BREATHE_TABLE [64] = '{
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd15,  8'd21,  8'd29,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd79,  8'd90,  8'd102, 8'd115,
    8'd127, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd225, 8'd233, 8'd240, 8'd245, 8'd249, 8'd252, 8'd254,
    8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd240, 8'd233, 8'd225,
    8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd140,
    8'd127, 8'd115, 8'd102, 8'd90,  8'd79,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd29,  8'd21,  8'd15,  8'd9,   8'd5,   8'd2,   8'd0
  };

  // floor(n / 255), exact for any product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = 17'(n) + 17'(n[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> rtl/core/bli_state_store.sv
// state store: status word and timer word, each a one-entry synchronous memory
// depends on bli_pkg
module bli_state_store #(
  parameter int PHASE_W = 6,
  parameter int COUNT_W = 16,
  parameter logic [COUNT_W-1:0] COUNT_RESET = 16'd3000
) (
  input  logic               clk,
  input  logic               rst,
  input  bli_pkg::mem_ctrl_t ctrl,
  input  logic [6:0]         wr_percent,
  input  logic               wr_usb,
  input  logic               wr_flash,
  input  logic [PHASE_W-1:0] wr_phase,
  input  logic               wr_armed,
  input  logic [COUNT_W-1:0] wr_count,
  output logic [6:0]         rd_percent,
  output logic               rd_usb,
  output logic               rd_flash,
  output logic [PHASE_W-1:0] rd_phase,
  output logic               rd_armed,
  output logic [COUNT_W-1:0] rd_count
);

  localparam int STATUS_W = 9 + PHASE_W;
  localparam int TIMER_W  = 1 + COUNT_W;
  localparam logic [STATUS_W-1:0] STATUS_RESET = {bli_pkg::LEVEL_FULL, 1'b0, 1'b0,
                                                  {PHASE_W{1'b0}}};
  localparam logic [TIMER_W-1:0] TIMER_RESET = {1'b1, COUNT_RESET};

  logic [STATUS_W-1:0] status_mem [1];
  logic [TIMER_W-1:0]  timer_mem  [1];
  logic                status_valid;
  logic                timer_valid;
  logic [STATUS_W-1:0] status_wdata;
  logic [TIMER_W-1:0]  timer_wdata;
  logic [STATUS_W-1:0] status_rd;
  logic [TIMER_W-1:0]  timer_rd;

  assign status_wdata = {wr_percent, wr_usb, wr_flash, wr_phase};
  assign timer_wdata  = {wr_armed, wr_count};

  always_ff @(posedge clk) begin
    if (ctrl.status_we) begin
      status_mem[0] <= status_wdata;
    end
    if (ctrl.timer_we) begin
      timer_mem[0] <= timer_wdata;
    end
  end

  // an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
      timer_valid  <= 1'b0;
    end else begin
      if (ctrl.status_we) status_valid <= 1'b1;
      if (ctrl.timer_we)  timer_valid  <= 1'b1;
    end
  end

  // registered read, write data forwarded on a same-edge write
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      if (ctrl.status_we) status_rd <= status_wdata;
      else if (status_valid) status_rd <= status_mem[0];
      else status_rd <= STATUS_RESET;
      if (ctrl.timer_we) timer_rd <= timer_wdata;
      else if (timer_valid) timer_rd <= timer_mem[0];
      else timer_rd <= TIMER_RESET;
    end
  end

  assign {rd_percent, rd_usb, rd_flash, rd_phase} = status_rd;
  assign {rd_armed, rd_count} = timer_rd;

endmodule

>>> rtl/core/bli_breathe_rom.sv
// breathing rom: 64 x 8 raised cosine table with a registered read port
// depends on bli_pkg for the table contents
module bli_breathe_rom (
  input  logic       clk,
  input  logic       rd_en,
  input  logic [5:0] addr,
  output logic [7:0] data
);

  logic [7:0] rom [64];

  assign rom = bli_pkg::BREATHE_TABLE;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom[addr];
    end
  end

endmodule

>>> rtl/core/bli_scaler.sv
// shared scaling unit: registered 8x8 product, quotient by 255 on its output
// depends on bli_pkg for div255
module bli_scaler (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] q
);

  logic [15:0] product;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= 16'(a) * 16'(b);
    end
  end

  assign q = bli_pkg::div255(product);

endmodule

>>> rtl/core/battery_led_indicator_sequencer.sv
// top level of the battery led indicator sequencer: request decode, frame control,
// register file; uses bli_pkg, bli_state_store, bli_breathe_rom, bli_scaler
`include "assert_macros.svh"

// Drives one RGB LED from a stream of requests: one-millisecond ticks, battery
// level reports and USB power reports. Level, power flag, flash flag, breathing
// phase and the millisecond countdown live in a small state store that is read
// when a request is taken and written back in the following cycle, so requests
// are handled one at a time. A request that produces no frame (a tick that does
// not expire, an unchanged report, the unused command) ends with the write back;
// a request that produces a frame runs state read, decide and write back with the
// breathing rom read, then two passes through the one shared multiply and
// divide-by-255 unit, and may then wait on frame_stall. The next request is taken
// as soon as the frame is parked in the output register. After reset the countdown
// is armed with startup_delay_ms; writing that register re-arms it. Powered and
// full gives solid green and stops the timer, powered otherwise breathes warm
// yellow one table step per step_interval_ms, unpowered below low_threshold
// toggles red every flash_half_period_ms, anything else is off with the timer
// stopped. Levels above 100 are taken as 100. Registers sit at byte addresses 4*i;
// the user must write configuration only while the block is idle (unchecked).
module battery_led_indicator_sequencer #(
  parameter int TABLE_STEPS = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [6:0]  level,
  input  logic        powered,
  // frame channel
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PHASE_W = $clog2(TABLE_STEPS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(bli_pkg::STARTUP_DELAY_RESET);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TABLE_STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_MUL1   = 6'b000100,
    S_DIV1   = 6'b001000,
    S_MUL2   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [6:0]  low_threshold;
  logic [15:0] flash_half_period_ms;
  logic [15:0] step_interval_ms;
  logic [7:0]  brightness_scale;
  logic [15:0] startup_delay_ms;
  logic [7:0]  yellow_green_ratio;

  // held request and frame context
  logic [1:0]          held_cmd;
  logic [6:0]          held_level;
  logic                held_powered;
  bli_pkg::pattern_t   pattern;
  logic                lit;
  logic [7:0]          scaled;

  // state store read side
  logic [6:0]             st_percent;
  logic                   st_usb;
  logic                   st_flash;
  logic [PHASE_W-1:0]     st_phase;
  logic                   st_armed;
  logic [COUNT_WIDTH-1:0] st_count;

  // decided next state
  logic [6:0]             n_percent;
  logic                   n_usb;
  logic                   n_flash;
  logic [PHASE_W-1:0]     n_phase;
  logic                   n_armed;
  logic [COUNT_WIDTH-1:0] n_count;
  logic                   run_frame;
  bli_pkg::pattern_t      n_pattern;
  logic                   n_lit;
  logic                   rom_en;
  logic [5:0]             rom_addr;
  logic [7:0]             level_sat;
  logic [7:0]             phase_wide;

  bli_pkg::mem_ctrl_t     mem_ctrl;
  logic                   wr_armed;
  logic [COUNT_WIDTH-1:0] wr_count;

  logic [7:0] rom_data;
  logic       scale_load;
  logic [7:0] scale_a;
  logic [7:0] scale_b;
  logic [7:0] scale_q;
  logic [7:0] operand;
  logic [7:0] red_next;
  logic [7:0] green_next;

  logic req_accept;
  logic cfg_write;
  logic delay_write;

  assign req_accept  = req_valid && !req_stall;
  assign req_stall   = (state != S_IDLE);
  assign cfg_write   = psel && penable && pwrite && pready;
  assign delay_write = cfg_write && (paddr[4:2] == bli_pkg::REG_STARTUP_DELAY);
  assign pready      = 1'b1;
  assign blue        = 8'd0;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold        <= bli_pkg::LOW_THRESHOLD_RESET;
      flash_half_period_ms <= bli_pkg::FLASH_HALF_RESET;
      step_interval_ms     <= bli_pkg::BREATHE_STEP_RESET;
      brightness_scale     <= bli_pkg::BRIGHTNESS_SCALE_RESET;
      startup_delay_ms     <= bli_pkg::STARTUP_DELAY_RESET;
      yellow_green_ratio   <= bli_pkg::YELLOW_GREEN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        bli_pkg::REG_LOW_THRESHOLD:    low_threshold        <= pwdata[6:0];
        bli_pkg::REG_FLASH_HALF:       flash_half_period_ms <= pwdata[15:0];
        bli_pkg::REG_BREATHE_STEP:     step_interval_ms     <= pwdata[15:0];
        bli_pkg::REG_BRIGHTNESS_SCALE: brightness_scale     <= pwdata[7:0];
        bli_pkg::REG_STARTUP_DELAY:    startup_delay_ms     <= pwdata[15:0];
        bli_pkg::REG_YELLOW_GREEN:     yellow_green_ratio   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bli_pkg::REG_LOW_THRESHOLD:    prdata = 32'(low_threshold);
      bli_pkg::REG_FLASH_HALF:       prdata = 32'(flash_half_period_ms);
      bli_pkg::REG_BREATHE_STEP:     prdata = 32'(step_interval_ms);
      bli_pkg::REG_BRIGHTNESS_SCALE: prdata = 32'(brightness_scale);
      bli_pkg::REG_STARTUP_DELAY:    prdata = 32'(startup_delay_ms);
      bli_pkg::REG_YELLOW_GREEN:     prdata = 32'(yellow_green_ratio);
      default:                       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- decide
  // works on the state word read at request time; result written back in S_EXEC
  always_comb begin
    n_percent = st_percent;
    n_usb     = st_usb;
    n_flash   = st_flash;
    n_phase   = st_phase;
    n_armed   = st_armed;
    n_count   = st_count;
    run_frame = 1'b0;
    n_pattern = bli_pkg::PAT_OFF;
    n_lit     = 1'b0;
    rom_en    = 1'b0;
    level_sat = (held_level > bli_pkg::LEVEL_FULL) ? 8'(bli_pkg::LEVEL_FULL)
                                                   : 8'(held_level);

    case (held_cmd)
      bli_pkg::CMD_TICK: begin
        if (st_armed) begin
          // a count of zero or one expires on this tick
          if (st_count <= COUNT_WIDTH'(1)) begin
            n_count   = '0;
            run_frame = 1'b1;
          end else begin
            n_count = st_count - COUNT_WIDTH'(1);
          end
        end
      end
      bli_pkg::CMD_LEVEL: begin
        if (level_sat[6:0] != st_percent) begin
          n_percent = level_sat[6:0];
          n_phase   = '0;
          n_flash   = 1'b0;
          run_frame = 1'b1;
        end
      end
      bli_pkg::CMD_POWER: begin
        if (held_powered != st_usb) begin
          n_usb     = held_powered;
          n_phase   = '0;
          n_flash   = 1'b0;
          run_frame = 1'b1;
        end
      end
      default: ;
    endcase

    // rom is addressed with the phase modulo the table size
    phase_wide = 8'(n_phase);
    rom_addr   = phase_wide[5:0];

    if (run_frame) begin
      if (n_usb) begin
        if (n_percent >= bli_pkg::LEVEL_FULL) begin
          n_pattern = bli_pkg::PAT_GREEN;
          n_armed   = 1'b0;
        end else begin
          n_pattern = bli_pkg::PAT_BREATHE;
          rom_en    = 1'b1;
          n_phase   = (n_phase == PHASE_LAST) ? '0 : n_phase + PHASE_W'(1);
          n_armed   = 1'b1;
          n_count   = COUNT_WIDTH'(step_interval_ms);
        end
      end else if (n_percent < low_threshold) begin
        n_flash   = !n_flash;
        n_pattern = bli_pkg::PAT_FLASH;
        n_lit     = n_flash;
        n_armed   = 1'b1;
        n_count   = COUNT_WIDTH'(flash_half_period_ms);
      end else begin
        n_pattern = bli_pkg::PAT_OFF;
        n_armed   = 1'b0;
      end
    end
  end

  // state store strobes; a start-up delay write re-arms the timer
  always_comb begin
    mem_ctrl.rd_en     = req_accept;
    mem_ctrl.status_we = (state == S_EXEC);
    mem_ctrl.timer_we  = (state == S_EXEC) || delay_write;
    if (delay_write) begin
      wr_armed = 1'b1;
      wr_count = COUNT_WIDTH'(pwdata[15:0]);
    end else begin
      wr_armed = n_armed;
      wr_count = n_count;
    end
  end

  bli_state_store #(
    .PHASE_W     (PHASE_W),
    .COUNT_W     (COUNT_WIDTH),
    .COUNT_RESET (COUNT_RESET)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mem_ctrl),
    .wr_percent (n_percent),
    .wr_usb     (n_usb),
    .wr_flash   (n_flash),
    .wr_phase   (n_phase),
    .wr_armed   (wr_armed),
    .wr_count   (wr_count),
    .rd_percent (st_percent),
    .rd_usb     (st_usb),
    .rd_flash   (st_flash),
    .rd_phase   (st_phase),
    .rd_armed   (st_armed),
    .rd_count   (st_count)
  );

  bli_breathe_rom u_rom (
    .clk   (clk),
    .rd_en (rom_en && (state == S_EXEC)),
    .addr  (rom_addr),
    .data  (rom_data)
  );

  // ---------------------------------------------------------------- scaling
  // first pass: operand * brightness_scale / 255, second: that * ratio / 255
  always_comb begin
    case (pattern)
      bli_pkg::PAT_GREEN:   operand = bli_pkg::FULL_SCALE;
      bli_pkg::PAT_BREATHE: operand = rom_data;
      bli_pkg::PAT_FLASH:   operand = lit ? bli_pkg::FULL_SCALE : 8'd0;
      default:              operand = 8'd0;
    endcase
  end

  assign scale_load = (state == S_MUL1) || (state == S_MUL2);
  assign scale_a    = (state == S_MUL2) ? scaled : operand;
  assign scale_b    = (state == S_MUL2) ? yellow_green_ratio : brightness_scale;

  bli_scaler u_scaler (
    .clk  (clk),
    .load (scale_load),
    .a    (scale_a),
    .b    (scale_b),
    .q    (scale_q)
  );

  always_comb begin
    case (pattern)
      bli_pkg::PAT_GREEN: begin
        red_next   = 8'd0;
        green_next = scaled;
      end
      bli_pkg::PAT_BREATHE: begin
        red_next   = scaled;
        green_next = scale_q;
      end
      bli_pkg::PAT_FLASH: begin
        red_next   = scaled;
        green_next = 8'd0;
      end
      default: begin
        red_next   = 8'd0;
        green_next = 8'd0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_accept) state_next = S_EXEC;
      S_EXEC:   state_next = run_frame ? S_MUL1 : S_IDLE;
      S_MUL1:   state_next = S_DIV1;
      S_DIV1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_FINISH;
      S_FINISH: if (!frame_valid || !frame_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && (!frame_valid || !frame_stall)) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      held_cmd     <= cmd;
      held_level   <= level;
      held_powered <= powered;
    end
    if (state == S_EXEC) begin
      pattern <= n_pattern;
      lit     <= n_lit;
    end
    if (state == S_DIV1) begin
      scaled <= scale_q;
    end
    if (state == S_FINISH && (!frame_valid || !frame_stall)) begin
      red   <= red_next;
      green <= green_next;
    end
  end

  // ---------------------------------------------------------------- checks
  `BLI_ASSERT(a_accept_goes_exec, clk, rst, req_accept |=> (state == S_EXEC))
  `BLI_ASSERT(a_frame_from_finish, clk, rst, $rose(frame_valid) |-> $past(state == S_FINISH))
  `BLI_ASSERT(a_taken_frame_clears, clk, rst, (frame_valid && !frame_stall && state != S_FINISH) |=> !frame_valid)
  `BLI_ASSERT_ALWAYS(a_store_no_overlap, clk, !(mem_ctrl.rd_en && mem_ctrl.status_we))

endmodule

>>> tb/battery_led_indicator_sequencer_test.sv
// self-checking testbench for the battery led indicator sequencer: directed and random requests
// against an in-bench prediction of every led frame; depends on bli_pkg and the rtl top level
module battery_led_indicator_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // the one command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // cycles without any handshake before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  // settling wait that lets an outstanding request finish
  localparam int SETTLE_CYCLES = 12;

  // raised cosine brightness table, one entry per breathing step
  localparam logic [7:0] GLOW_TABLE [64] = '{
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd15,  8'd21,  8'd29,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd79,  8'd90,  8'd102, 8'd115,
    8'd127, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
    8'd217, 8'd225, 8'd233, 8'd240, 8'd245, 8'd249, 8'd252, 8'd254,
    8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd240, 8'd233, 8'd225,
    8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd140,
    8'd127, 8'd115, 8'd102, 8'd90,  8'd79,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd29,  8'd21,  8'd15,  8'd9,   8'd5,   8'd2,   8'd0
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  cmd = bli_pkg::CMD_TICK;
  logic [6:0]  level = 7'd0;
  logic        powered = 1'b0;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predicted register contents, reset values to start with
  logic [6:0]  thr_pct = bli_pkg::LOW_THRESHOLD_RESET;
  logic [15:0] flash_ms = bli_pkg::FLASH_HALF_RESET;
  logic [15:0] step_ms = bli_pkg::BREATHE_STEP_RESET;
  logic [7:0]  glow_scale = bli_pkg::BRIGHTNESS_SCALE_RESET;
  logic [7:0]  yellow_share = bli_pkg::YELLOW_GREEN_RESET;

  // predicted sequencer state; the countdown starts armed at the start-up delay
  logic [6:0]  pct = bli_pkg::LEVEL_FULL;
  logic        usb = 1'b0;
  logic        lit = 1'b0;
  logic [5:0]  phase = 6'd0;
  logic [15:0] remain = bli_pkg::STARTUP_DELAY_RESET;
  logic        armed = 1'b1;

  led_frame_t expected_frames[$];
  int         failures = 0;
  int         requests_sent = 0;
  int         quiet_cycles = 0;
  bit         idling = 1'b1;

  battery_led_indicator_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .level       (level),
    .powered     (powered),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame prediction
  // ---------------------------------------------------------------------------

  // colour value times the brightness setting, floor division by full scale
  function automatic logic [7:0] scaled(input logic [7:0] x);
    return 8'((int'(x) * int'(glow_scale)) / 255);
  endfunction

  // one frame from the stored level and power flag; updates phase, flash and timer
  task automatic predict_led_frame();
    led_frame_t f;
    f = '0;
    if (usb) begin
      if (pct >= bli_pkg::LEVEL_FULL) begin
        // powered and full: solid green, timer stops
        f.green = scaled(bli_pkg::FULL_SCALE);
        armed = 1'b0;
      end else begin
        // warm yellow breathing, green is a share of red
        f.red = scaled(GLOW_TABLE[phase]);
        f.green = 8'((int'(f.red) * int'(yellow_share)) / 255);
        phase = phase + 6'd1;  // six bits wrap at the 64 table steps
        armed = 1'b1;
        remain = step_ms;
      end
    end else if (pct < thr_pct) begin
      // unpowered and low: red toggles each frame
      lit = !lit;
      f.red = lit ? scaled(bli_pkg::FULL_SCALE) : 8'd0;
      armed = 1'b1;
      remain = flash_ms;
    end else begin
      // nothing to show, timer stops
      armed = 1'b0;
    end
    expected_frames.push_back(f);
  endtask

  // state update for one accepted request, queuing a frame where one is due
  task automatic predict_request(input logic [1:0] c, input logic [6:0] lv, input logic pw);
    logic [6:0] sat;
    sat = (lv > bli_pkg::LEVEL_FULL) ? bli_pkg::LEVEL_FULL : lv;
    case (c)
      bli_pkg::CMD_TICK: begin
        if (armed) begin
          // a countdown of zero or one expires on this tick
          if (remain <= 16'd1) begin
            remain = 16'd0;
            predict_led_frame();
          end else begin
            remain = remain - 16'd1;
          end
        end
      end
      bli_pkg::CMD_LEVEL: begin
        if (sat != pct) begin
          pct = sat;
          phase = 6'd0;
          lit = 1'b0;
          predict_led_frame();
        end
      end
      bli_pkg::CMD_POWER: begin
        if (pw != usb) begin
          usb = pw;
          phase = 6'd0;
          lit = 1'b0;
          predict_led_frame();
        end
      end
      default: ;  // unused command is dropped
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request side, register port and frame stall
  // ---------------------------------------------------------------------------

  // offers one request, with a random gap in front while idling is on,
  // and predicts its effect at the edge where it is taken
  task automatic send_request(input logic [1:0] c, input logic [6:0] lv, input logic pw);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    level <= lv;
    powered <= pw;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request(c, lv, pw);
    if (c != CMD_UNUSED) requests_sent++;
  endtask

  // setup and access phase; the predicted register follows at the write edge
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bli_pkg::REG_LOW_THRESHOLD:    thr_pct = value[6:0];
      bli_pkg::REG_FLASH_HALF:       flash_ms = value[15:0];
      bli_pkg::REG_BREATHE_STEP:     step_ms = value[15:0];
      bli_pkg::REG_BRIGHTNESS_SCALE: glow_scale = value[7:0];
      bli_pkg::REG_STARTUP_DELAY: begin
        // restarts the start-up delay
        remain = value[15:0];
        armed = 1'b1;
      end
      bli_pkg::REG_YELLOW_GREEN:     yellow_share = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // lets every predicted frame come out, then gives a request without a frame
  // time to finish so the block is idle
  task automatic drain_frames();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers are only touched with the block idle; start-up delay last since it arms
  task automatic apply_settings(input int thr, input int flash, input int step,
                                input int bright, input int start, input int yg);
    drain_frames();
    write_register(bli_pkg::REG_LOW_THRESHOLD, thr);
    write_register(bli_pkg::REG_FLASH_HALF, flash);
    write_register(bli_pkg::REG_BREATHE_STEP, step);
    write_register(bli_pkg::REG_BRIGHTNESS_SCALE, bright);
    write_register(bli_pkg::REG_YELLOW_GREEN, yg);
    write_register(bli_pkg::REG_STARTUP_DELAY, start);
  endtask

  // receiver stalls in random-length bursts, none once idling is off
  always begin
    @(posedge clk);
    if (idling && !rst && $urandom_range(0, 5) == 0) begin
      frame_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      frame_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // frame checking and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_frames
    led_frame_t want;
    if (!rst && frame_valid && !frame_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame red %0d green %0d blue %0d", red, green, blue);
        failures++;
      end else begin
        want = expected_frames.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          failures++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          failures++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          failures++;
        end
      end
    end
  end

  // any request, frame or register access counts as progress
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (frame_valid && !frame_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // levels around the threshold, at full, in range and beyond 100
  function automatic logic [6:0] pick_level();
    int t;
    t = thr_pct;
    case ($urandom_range(0, 3))
      0: return 7'($urandom_range(0, 127));
      1: return 7'($urandom_range((t > 0) ? t - 1 : 0, t));
      2: return bli_pkg::LEVEL_FULL;
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  // one or two reports, then a run of ticks with the odd unused command mixed in;
  // long runs let breathing wrap the table and flashing toggle many times
  task automatic run_episode();
    int ticks;
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 1) == 1)
        send_request(bli_pkg::CMD_LEVEL, pick_level(), 1'($urandom_range(0, 1)));
      else
        send_request(bli_pkg::CMD_POWER, 7'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
    end
    ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0)
        send_request(CMD_UNUSED, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      else
        send_request(bli_pkg::CMD_TICK, 7'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_requests(input int count);
    int target;
    target = requests_sent + count;
    while (requests_sent < target) run_episode();
  endtask

  // reset values, unchanged and saturating reports, unused command, every pattern
  task automatic test_reports();
    send_request(CMD_UNUSED, 7'd0, 1'b1);
    send_request(bli_pkg::CMD_LEVEL, 7'd100, 1'b0);
    send_request(bli_pkg::CMD_LEVEL, 7'd127, 1'b1);  // saturates to the stored 100
    send_request(bli_pkg::CMD_LEVEL, 7'd0, 1'b0);    // red flash lit
    send_request(bli_pkg::CMD_LEVEL, 7'd0, 1'b1);
    send_request(bli_pkg::CMD_POWER, 7'd127, 1'b0);
    send_request(bli_pkg::CMD_POWER, 7'd0, 1'b1);    // breathing from the first step
    send_request(bli_pkg::CMD_TICK, 7'd55, 1'b0);
    send_request(bli_pkg::CMD_LEVEL, 7'd127, 1'b0);  // powered and full: green
    send_request(bli_pkg::CMD_TICK, 7'd0, 1'b1);     // timer stopped
    send_request(bli_pkg::CMD_LEVEL, 7'd99, 1'b0);
    send_request(bli_pkg::CMD_POWER, 7'd0, 1'b0);    // at or above threshold: off
    send_request(bli_pkg::CMD_LEVEL, 7'd89, 1'b1);
    send_request(bli_pkg::CMD_LEVEL, 7'd101, 1'b0);
  endtask

  // start-up delay write restarts the countdown; zero expires on the first tick
  task automatic test_startup_delay();
    drain_frames();
    write_register(bli_pkg::REG_STARTUP_DELAY, 2);
    repeat (3) send_request(bli_pkg::CMD_TICK, 7'd127, 1'b1);
    drain_frames();
    write_register(bli_pkg::REG_STARTUP_DELAY, 0);
    send_request(bli_pkg::CMD_TICK, 7'd0, 1'b0);
  endtask

  // a zero reload expires on the very next tick
  task automatic test_zero_period();
    apply_settings(bli_pkg::LOW_THRESHOLD_RESET, 0, 1, bli_pkg::BRIGHTNESS_SCALE_RESET, 0,
                   bli_pkg::YELLOW_GREEN_RESET);
    send_request(bli_pkg::CMD_LEVEL, 7'd10, 1'b0);
    repeat (2) send_request(bli_pkg::CMD_TICK, 7'd0, 1'b0);
    send_request(bli_pkg::CMD_POWER, 7'd0, 1'b1);
    repeat (3) send_request(bli_pkg::CMD_TICK, 7'd127, 1'b0);
  endtask

  // extremes of every register, threshold beyond 100 included
  task automatic test_setting_extremes();
    apply_settings(0, 1, 1, 0, 0, 0);
    run_requests(150);
    apply_settings(100, 0, 0, 255, 1, 255);
    run_requests(200);
    apply_settings(127, 2, 3, 128, 5, 100);
    run_requests(200);
    // long periods: frames only from reports, the countdown never runs out
    apply_settings(90, 65535, 65535, 180, 65535, 200);
    run_requests(150);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      apply_settings($urandom_range(0, 127), $urandom_range(0, 10), $urandom_range(0, 10),
                     $urandom_range(0, 255), $urandom_range(0, 30), $urandom_range(0, 255));
      run_requests(250);
    end
  endtask

  // back-to-back requests with the receiver never stalling
  task automatic test_full_rate();
    drain_frames();
    idling = 1'b0;
    apply_settings($urandom_range(0, 127), $urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 255), $urandom_range(0, 10), $urandom_range(0, 255));
    run_requests(250);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reports();
    test_startup_delay();
    test_zero_period();
    test_setting_extremes();
    test_random_settings();
    test_full_rate();
    drain_frames();
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
